// File: rtl/core/uar_pkg.sv
// Shared types, codes and the digit character lookup of the radix conversion unit.
package uar_pkg;

	typedef enum logic [1:0] {
		OP_DEC    = 2'd0,
		OP_OCT    = 2'd1,
		OP_HEX_LO = 2'd2,
		OP_HEX_UP = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CONV = 3'b010,
		F_DONE = 3'b100
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_SKIP = 3'b010,
		B_EMIT = 3'b100
	} back_state_t;

	localparam logic [127:0] LOWER_DIGITS = "0123456789abcdef";
	localparam logic [127:0] UPPER_DIGITS = "0123456789ABCDEF";

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [6:0] pos;
		pos = 7'(8 * (15 - int'(d)));
		digit_char = upper ? UPPER_DIGITS[pos +: 8] : LOWER_DIGITS[pos +: 8];
	endfunction

endpackage

// File: rtl/core/uar_front.sv
// Front part: accepts a request and turns the value into packed digit slots.
module uar_front import uar_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int SLOTS       = (VALUE_WIDTH + 2) / 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [1:0]             op,
	output logic                   push_valid,
	input  logic                   push_ready,
	output logic [SLOTS*4-1:0]     push_digits,
	output logic                   push_upper
);

	localparam int DW = SLOTS * 4;
	localparam int OW = SLOTS * 3;
	localparam int CW = $clog2(VALUE_WIDTH + 1);

	front_state_t           state_q;
	logic [CW-1:0]          step_q;
	logic [VALUE_WIDTH-1:0] shift_q;
	logic [DW-1:0]          digits_q;
	logic                   upper_q;

	op_t           op_v;
	logic [OW-1:0] vo;
	logic [DW-1:0] vh;
	logic [DW-1:0] oct_digits;
	logic [DW-1:0] adj;
	logic [DW-1:0] next_bcd;

	always_comb begin
		op_v = op_t'(op);
		vo   = OW'(value);
		vh   = DW'(value);
		for (int i = 0; i < SLOTS; i++) begin
			oct_digits[4*i +: 4] = {1'b0, vo[3*i +: 3]};
			adj[4*i +: 4] = (digits_q[4*i +: 4] >= 4'd5) ? digits_q[4*i +: 4] + 4'd3
				: digits_q[4*i +: 4];
		end
		next_bcd = {adj[DW-2:0], shift_q[VALUE_WIDTH-1]};
	end

	assign req_ready   = (state_q == F_IDLE);
	assign push_valid  = (state_q == F_DONE);
	assign push_digits = digits_q;
	assign push_upper  = upper_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (req_valid) begin
						if (op_v == OP_DEC) begin
							step_q  <= CW'(VALUE_WIDTH);
							state_q <= F_CONV;
						end else begin
							state_q <= F_DONE;
						end
					end
				end
				F_CONV: begin
					step_q <= step_q - CW'(1);
					if (step_q == CW'(1)) begin
						state_q <= F_DONE;
					end
				end
				F_DONE: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && req_valid) begin
			upper_q <= (op_v == OP_HEX_UP);
			shift_q <= value;
			unique case (op_v)
				OP_DEC:  digits_q <= '0;
				OP_OCT:  digits_q <= oct_digits;
				default: digits_q <= vh;
			endcase
		end else if (state_q == F_CONV) begin
			digits_q <= next_bcd;
			shift_q  <= shift_q << 1;
		end
	end

endmodule

// File: rtl/core/uar_fifo.sv
// Two-entry queue between the front and back parts.
module uar_fifo #(
	parameter int WIDTH = 45
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/core/uar_back.sv
// Back part: skips leading zero slots and sends one character per cycle while the output is not stalled.
module uar_back import uar_pkg::*; #(
	parameter int SLOTS = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  logic [SLOTS*4-1:0] pop_digits,
	input  logic               pop_upper,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [7:0]         ascii_char,
	output logic               is_last,
	output logic [3:0]         char_count
);

	localparam int IW = $clog2(SLOTS);
	localparam int NW = $clog2(SLOTS + 1);

	back_state_t        state_q;
	logic [IW-1:0]      idx_q;
	logic [NW-1:0]      cnt_q;
	logic [SLOTS*4-1:0] digits_q;
	logic               upper_q;
	logic               rsp_valid_q;
	logic [7:0]         ascii_char_q;
	logic               is_last_q;
	logic [3:0]         char_count_q;

	logic [3:0]    cur_digit;
	logic          out_free;
	logic          emit;
	logic          at_end;
	logic [NW-1:0] cnt_next;

	assign cur_digit = digits_q[4*idx_q +: 4];
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign emit      = (state_q == B_EMIT) && out_free;
	assign at_end    = (idx_q == '0);
	assign cnt_next  = cnt_q + NW'(1);
	assign pop_ready = (state_q == B_IDLE);

	assign rsp_valid  = rsp_valid_q;
	assign ascii_char = ascii_char_q;
	assign is_last    = is_last_q;
	assign char_count = char_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						idx_q   <= IW'(SLOTS - 1);
						cnt_q   <= '0;
						state_q <= B_SKIP;
					end
				end
				B_SKIP: begin
					if (cur_digit != 4'd0 || at_end) begin
						state_q <= B_EMIT;
					end else begin
						idx_q <= idx_q - IW'(1);
					end
				end
				B_EMIT: begin
					if (out_free) begin
						cnt_q <= cnt_next;
						if (at_end) begin
							state_q <= B_IDLE;
						end else begin
							idx_q <= idx_q - IW'(1);
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop_valid) begin
			digits_q <= pop_digits;
			upper_q  <= pop_upper;
		end
		if (emit) begin
			ascii_char_q <= digit_char(cur_digit, upper_q);
			is_last_q    <= at_end;
			char_count_q <= at_end ? 4'(cnt_next) : 4'd0;
		end
	end

endmodule

// File: rtl/core/unsigned_to_ascii_radix_unit.sv
// Top level of the unsigned binary to ASCII decimal, octal and hex converter.
// Each request carries an unsigned value and a format code (decimal, octal,
// lowercase hex, uppercase hex); the unit returns its digits most significant
// first with no leading zeros, one character per response, the last one flagged
// and carrying the character count modulo 16. A decimal request passes through the
// double-dabble shifter of the front part, which shifts in every bit of the value
// most significant first; octal and hex requests leave the front part without it.
// The back part loads an entry, skips leading zero digit slots one at a time until
// it finds the first digit and then sends one character per cycle while the output
// is not stalled, and it overlaps the front part through a two-entry queue, so the
// sustained rate is the slower of the two.
module unsigned_to_ascii_radix_unit import uar_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [1:0]             op,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output logic [7:0]             ascii_char,
	output logic                   is_last,
	output logic [3:0]             char_count
);

	localparam int SLOTS = (VALUE_WIDTH + 2) / 3;
	localparam int QW    = SLOTS * 4 + 1;

	logic              f_valid;
	logic              f_ready;
	logic [SLOTS*4-1:0] f_digits;
	logic              f_upper;
	logic              b_valid;
	logic              b_ready;
	logic [QW-1:0]     b_data;

	uar_front #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.SLOTS      (SLOTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.value      (value),
		.op         (op),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_digits(f_digits),
		.push_upper (f_upper)
	);

	uar_fifo #(
		.WIDTH(QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data ({f_upper, f_digits}),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_data)
	);

	uar_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_digits(b_data[SLOTS*4-1:0]),
		.pop_upper (b_data[QW-1]),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ascii_char(ascii_char),
		.is_last   (is_last),
		.char_count(char_count)
	);

endmodule
